>>> src/fpm_pkg.sv
// ----------------------------------------------------------------------------
// fpm_pkg
// Types and constants shared by the flash page mapper modules.
// ----------------------------------------------------------------------------
package fpm_pkg;

    localparam int         PAGE_BYTES = 256;
    localparam logic [7:0] ERASED     = 8'hff;
    localparam logic [8:0] SWEEP_END  = 9'(PAGE_BYTES);

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_ADDR,
        ST_BAD_LEN,
        ST_NO_MEM,
        ST_UNMAPPED
    } status_t;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_RANGE,
        CMD_FLUSH
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_TABLE_PAGE,
        CFG_REGION_PAGES,
        CFG_AUTO_ALLOCATE
    } cfg_index_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_RANGE,
        OP_FLUSH,
        OP_FAIL
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        status_t    fail_status;
        logic [7:0] vpage;
        logic [7:0] offset;
        logic [7:0] data;
        logic       force_rd;
        logic       in_map;
        logic [8:0] range_end;
    } op_t;

    typedef struct packed {
        logic [7:0] table_page;
        logic [6:0] region_pages;
        logic       auto_allocate;
    } cfg_t;

    // lowest bits first: status, read_data, flushed, page_mapped
    typedef struct packed {
        logic       page_mapped;
        logic       flushed;
        logic [7:0] read_data;
        status_t    status;
    } result_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_WB,
        BK_SWITCH,
        BK_LOAD,
        BK_WRITE_ALLOC,
        BK_WRITE,
        BK_READ,
        BK_READ_WAIT,
        BK_ALLOC,
        BK_SCAN,
        BK_ALLOC_CHECK,
        BK_ALLOC_COMMIT,
        BK_RANGE_RD,
        BK_RANGE_CHK,
        BK_RANGE_NEXT,
        BK_DONE
    } back_state_t;

endpackage

>>> src/fpm_front.sv
// ----------------------------------------------------------------------------
// fpm_front
// Accepts input words, checks addresses and lengths, and hands out decoded ops.
// ----------------------------------------------------------------------------
module fpm_front #(
    parameter int MAP_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,  // address, write_data, length_bytes, force_flash, zero pad
    input  logic [1:0]    s_tuser,  // cmd
    output logic          op_valid,
    input  logic          op_ready,
    output fpm_pkg::op_t  op
);
    import fpm_pkg::*;

    localparam logic [8:0] MAP_LIMIT = 9'(MAP_ENTRIES);

    logic        valid_reg, valid_next;
    op_t         op_reg, op_next;
    logic [15:0] addr;
    logic [16:0] len;
    logic [7:0]  vp;
    logic        in_map;
    logic [9:0]  range_sum;
    op_t         dec;

    assign addr      = s_tdata[15:0];
    assign len       = s_tdata[40:24];
    assign vp        = addr[15:8];
    assign in_map    = {1'b0, vp} < MAP_LIMIT;
    assign range_sum = {2'b00, vp} + {1'b0, len[16:8]};

    always_comb
    begin
        dec             = '0;
        dec.vpage       = vp;
        dec.offset      = addr[7:0];
        dec.data        = s_tdata[23:16];
        dec.force_rd    = s_tdata[41];
        dec.in_map      = in_map;
        dec.range_end   = range_sum[8:0];
        dec.fail_status = ST_OK;
        dec.kind        = OP_FAIL;
        unique case (cmd_t'(s_tuser))
            CMD_READ, CMD_WRITE:
            begin
                if (!in_map)
                    dec.fail_status = ST_BAD_ADDR;
                else
                    dec.kind = (cmd_t'(s_tuser) == CMD_READ) ? OP_READ : OP_WRITE;
            end
            CMD_RANGE:
            begin
                if (len == 17'd0 || len[7:0] != 8'd0)
                    dec.fail_status = ST_BAD_LEN;
                else if (addr[7:0] != 8'd0 || !in_map)
                    dec.fail_status = ST_BAD_ADDR;
                else if (range_sum > {1'b0, MAP_LIMIT})
                    dec.fail_status = ST_BAD_LEN;
                else
                    dec.kind = OP_RANGE;
            end
            CMD_FLUSH:
                dec.kind = OP_FLUSH;
            default:
                dec.kind = OP_FAIL;
        endcase
    end

    assign s_tready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_comb
    begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (op_ready)
            valid_next = 1'b0;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
            op_next    = dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

endmodule

>>> src/fpm_queue.sv
// ----------------------------------------------------------------------------
// fpm_queue
// Two-entry queue of decoded ops between the front and the back.
// ----------------------------------------------------------------------------
module fpm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fpm_pkg::op_t  in_op,
    output logic          out_valid,
    input  logic          out_ready,
    output fpm_pkg::op_t  out_op
);
    import fpm_pkg::*;

    op_t        mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_op    = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_op;
    end

endmodule

>>> src/fpm_back.sv
// ----------------------------------------------------------------------------
// fpm_back
// Carries out ops against the page map, write buffer and flash store.
// ----------------------------------------------------------------------------
module fpm_back #(
    parameter int MAP_ENTRIES = 256,
    parameter int DATA_PAGES  = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fpm_pkg::cfg_t   cfg,
    input  logic            op_valid,
    output logic            op_ready,
    input  fpm_pkg::op_t    op_in,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata
);
    import fpm_pkg::*;

    localparam int         MI          = $clog2(MAP_ENTRIES);
    localparam int         SB          = (DATA_PAGES > 1) ? $clog2(DATA_PAGES) : 1;
    localparam int         FA          = SB + 8;
    localparam int         FLASH_DEPTH = DATA_PAGES * PAGE_BYTES;
    localparam logic [8:0] MAP_COUNT   = 9'(MAP_ENTRIES);
    localparam logic [7:0] DATA_PAGES_W = 8'(DATA_PAGES);

    function automatic logic slot_ok(input logic [7:0] page, input logic [7:0] tpage);
        logic [7:0] diff;
        diff = page - tpage - 8'd1;
        return (page > tpage) && (diff < DATA_PAGES_W);
    endfunction

    function automatic logic [SB-1:0] slot_idx(input logic [7:0] page,
                                               input logic [7:0] tpage);
        logic [7:0] diff;
        diff = page - tpage - 8'd1;
        return diff[SB-1:0];
    endfunction

    back_state_t state_reg, state_next;
    back_state_t wb_ret_reg, wb_ret_next;
    back_state_t alloc_ret_reg, alloc_ret_next;
    op_t         op_reg, op_next;
    logic [7:0]  fp_reg, fp_next;
    logic [7:0]  buf_page_reg, buf_page_next;
    logic        dirty_reg, dirty_next;
    logic [7:0]  last_reg, last_next;
    status_t     status_reg, status_next;
    logic [7:0]  rd_reg, rd_next;
    logic        flushed_reg, flushed_next;
    logic        mapped_reg, mapped_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [8:0]  range_p_reg, range_p_next;
    logic [7:0]  alloc_vp_reg, alloc_vp_next;
    logic        sel_buf_reg, sel_buf_next;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_load;
    result_t     result;

    // page map
    logic [7:0]             map_mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] map_valid_reg;
    logic [MI-1:0]          map_rd_addr;
    logic [7:0]             map_rd_data_reg;
    logic                   map_rd_vld_reg;
    logic                   map_wr_en;
    logic [MI-1:0]          map_wr_addr;
    logic [7:0]             map_val;

    // write buffer
    logic [7:0]            buf_mem [PAGE_BYTES];
    logic [PAGE_BYTES-1:0] buf_valid_reg;
    logic [7:0]            buf_rd_addr;
    logic [7:0]            buf_rd_data_reg;
    logic                  buf_rd_vld_reg;
    logic                  buf_wr_en;
    logic [7:0]            buf_wr_addr;
    logic [7:0]            buf_wr_data;
    logic                  buf_clear;
    logic [7:0]            buf_val;

    // flash store, one row per data page
    logic [7:0]            flash_mem [FLASH_DEPTH];
    logic [DATA_PAGES-1:0] row_valid_reg;
    logic [FA-1:0]         flash_rd_addr;
    logic                  flash_rd_ok;
    logic [7:0]            flash_rd_data_reg;
    logic                  flash_rd_ok_reg;
    logic                  flash_wr_en;
    logic [FA-1:0]         flash_wr_addr;
    logic                  row_set;
    logic [7:0]            flash_val;

    logic          fp_ok, bp_ok;
    logic [SB-1:0] fp_slot, bp_slot;
    logic [8:0]    sweep_prev;
    logic [6:0]    cap_raw;
    logic [7:0]    cap;
    logic [8:0]    end_sum, end_pg, start_pg;
    logic          no_mem;

    assign map_val   = map_rd_vld_reg ? map_rd_data_reg : 8'd0;
    assign buf_val   = buf_rd_vld_reg ? buf_rd_data_reg : 8'd0;
    assign flash_val = flash_rd_ok_reg ? flash_rd_data_reg : ERASED;

    assign fp_ok      = slot_ok(fp_reg, cfg.table_page);
    assign fp_slot    = slot_idx(fp_reg, cfg.table_page);
    assign bp_ok      = slot_ok(buf_page_reg, cfg.table_page);
    assign bp_slot    = slot_idx(buf_page_reg, cfg.table_page);
    assign sweep_prev = cnt_reg - 9'd1;

    // region end and next free page
    assign cap_raw  = (cfg.region_pages != 7'd0) ? cfg.region_pages - 7'd1 : 7'd0;
    assign cap      = ({1'b0, cap_raw} > DATA_PAGES_W) ? DATA_PAGES_W : {1'b0, cap_raw};
    assign end_sum  = {1'b0, cfg.table_page} + {1'b0, cap};
    assign end_pg   = (end_sum > 9'd255) ? 9'd255 : end_sum;
    assign start_pg = (last_reg <= cfg.table_page) ? {1'b0, cfg.table_page} + 9'd1
                                                   : {1'b0, last_reg} + 9'd1;
    assign no_mem   = start_pg > end_pg;

    assign op_ready = state_reg == BK_IDLE;
    assign out_load = (state_reg == BK_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (op_valid)
                    state_next = BK_LOOKUP;
            BK_LOOKUP:
            begin
                case (op_reg.kind)
                    OP_FLUSH:
                        state_next = dirty_reg ? BK_WB : BK_DONE;
                    OP_READ:
                        state_next = (op_reg.force_rd && dirty_reg) ? BK_WB : BK_READ;
                    OP_WRITE:
                    begin
                        if (map_val == 8'd0 && !cfg.auto_allocate)
                            state_next = BK_DONE;
                        else if (buf_page_reg != map_val)
                            state_next = dirty_reg ? BK_WB : BK_SWITCH;
                        else
                            state_next = BK_WRITE_ALLOC;
                    end
                    OP_RANGE:
                        state_next = BK_RANGE_RD;
                    default:
                        state_next = BK_DONE;
                endcase
            end
            BK_WB:
                if (cnt_reg == SWEEP_END)
                    state_next = wb_ret_reg;
            BK_SWITCH:
                state_next = (fp_reg != 8'd0) ? BK_LOAD : BK_WRITE_ALLOC;
            BK_LOAD:
                if (cnt_reg == SWEEP_END)
                    state_next = BK_WRITE_ALLOC;
            BK_WRITE_ALLOC:
                state_next = (fp_reg == 8'd0) ? BK_ALLOC : BK_WRITE;
            BK_WRITE:
                state_next = BK_DONE;
            BK_READ:
                state_next = (fp_reg == 8'd0) ? BK_DONE : BK_READ_WAIT;
            BK_READ_WAIT:
                state_next = BK_DONE;
            BK_ALLOC:
                state_next = (last_reg == 8'd0) ? BK_SCAN : BK_ALLOC_CHECK;
            BK_SCAN:
                if (cnt_reg == MAP_COUNT)
                    state_next = BK_ALLOC_CHECK;
            BK_ALLOC_CHECK:
            begin
                if (no_mem)
                    state_next = alloc_ret_reg;
                else
                    state_next = dirty_reg ? BK_WB : BK_ALLOC_COMMIT;
            end
            BK_ALLOC_COMMIT:
                state_next = alloc_ret_reg;
            BK_RANGE_RD:
            begin
                if (range_p_reg == op_reg.range_end)
                    state_next = dirty_reg ? BK_WB : BK_DONE;
                else
                    state_next = BK_RANGE_CHK;
            end
            BK_RANGE_CHK:
                state_next = (map_val == 8'd0) ? BK_ALLOC : BK_RANGE_NEXT;
            BK_RANGE_NEXT:
                state_next = (status_reg != ST_OK) ? BK_DONE : BK_RANGE_RD;
            BK_DONE:
                if (!out_valid_reg || m_tready)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        wb_ret_next    = wb_ret_reg;
        alloc_ret_next = alloc_ret_reg;
        op_next        = op_reg;
        fp_next        = fp_reg;
        buf_page_next  = buf_page_reg;
        dirty_next     = dirty_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        flushed_next   = flushed_reg;
        mapped_next    = mapped_reg;
        cnt_next       = 9'd0;
        range_p_next   = range_p_reg;
        alloc_vp_next  = alloc_vp_reg;
        sel_buf_next   = sel_buf_reg;

        map_rd_addr   = op_reg.vpage[MI-1:0];
        map_wr_en     = 1'b0;
        map_wr_addr   = alloc_vp_reg[MI-1:0];
        buf_rd_addr   = op_reg.offset;
        buf_wr_en     = 1'b0;
        buf_wr_addr   = op_reg.offset;
        buf_wr_data   = op_reg.data;
        buf_clear     = 1'b0;
        flash_rd_addr = {fp_slot, op_reg.offset};
        flash_rd_ok   = fp_ok && row_valid_reg[fp_slot];
        flash_wr_en   = 1'b0;
        flash_wr_addr = {bp_slot, sweep_prev[7:0]};
        row_set       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                map_rd_addr = op_in.vpage[MI-1:0];
                if (op_valid)
                begin
                    op_next      = op_in;
                    status_next  = (op_in.kind == OP_FAIL) ? op_in.fail_status : ST_OK;
                    rd_next      = 8'd0;
                    flushed_next = 1'b0;
                    mapped_next  = 1'b0;
                end
            end
            BK_LOOKUP:
            begin
                fp_next      = map_val;
                mapped_next  = map_val != 8'd0;
                range_p_next = {1'b0, op_reg.vpage};
                case (op_reg.kind)
                    OP_READ:  wb_ret_next = BK_READ;
                    OP_WRITE: wb_ret_next = BK_SWITCH;
                    default:  wb_ret_next = BK_DONE;
                endcase
                if (op_reg.kind == OP_WRITE && map_val == 8'd0 && !cfg.auto_allocate)
                    status_next = ST_UNMAPPED;
            end
            BK_WB:
            begin
                // read buffer byte n while byte n-1 goes to flash
                buf_rd_addr = cnt_reg[7:0];
                flash_wr_en = bp_ok && (cnt_reg != 9'd0);
                if (cnt_reg == SWEEP_END)
                begin
                    dirty_next   = 1'b0;
                    flushed_next = 1'b1;
                    row_set      = bp_ok;
                end
                else
                    cnt_next = cnt_reg + 9'd1;
            end
            BK_SWITCH:
                buf_page_next = fp_reg;
            BK_LOAD:
            begin
                flash_rd_addr = {fp_slot, cnt_reg[7:0]};
                buf_wr_en     = cnt_reg != 9'd0;
                buf_wr_addr   = sweep_prev[7:0];
                buf_wr_data   = flash_val;
                if (cnt_reg != SWEEP_END)
                    cnt_next = cnt_reg + 9'd1;
            end
            BK_WRITE_ALLOC:
            begin
                alloc_vp_next  = op_reg.vpage;
                alloc_ret_next = BK_WRITE;
            end
            BK_WRITE:
            begin
                if (status_reg == ST_OK)
                begin
                    buf_wr_en  = 1'b1;
                    dirty_next = 1'b1;
                end
            end
            BK_READ:
            begin
                sel_buf_next = (fp_reg == buf_page_reg) && !op_reg.force_rd;
                if (fp_reg == 8'd0)
                    status_next = ST_UNMAPPED;
            end
            BK_READ_WAIT:
                rd_next = sel_buf_reg ? buf_val : flash_val;
            BK_SCAN:
            begin
                // map entry n is read while entry n-1 is compared
                map_rd_addr = cnt_reg[MI-1:0];
                if (cnt_reg != 9'd0 && map_val > last_reg)
                    last_next = map_val;
                if (cnt_reg != MAP_COUNT)
                    cnt_next = cnt_reg + 9'd1;
            end
            BK_ALLOC_CHECK:
            begin
                wb_ret_next = BK_ALLOC_COMMIT;
                if (no_mem)
                    status_next = ST_NO_MEM;
                else
                    last_next = start_pg[7:0];
            end
            BK_ALLOC_COMMIT:
            begin
                map_wr_en     = 1'b1;
                buf_page_next = last_reg;
                buf_clear     = 1'b1;
                dirty_next    = 1'b0;
                if (alloc_vp_reg == op_reg.vpage)
                    mapped_next = 1'b1;
            end
            BK_RANGE_RD:
            begin
                map_rd_addr = range_p_reg[MI-1:0];
                wb_ret_next = BK_DONE;
            end
            BK_RANGE_CHK:
            begin
                alloc_vp_next  = range_p_reg[7:0];
                alloc_ret_next = BK_RANGE_NEXT;
            end
            BK_RANGE_NEXT:
                range_p_next = range_p_reg + 9'd1;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.status      = status_reg;
        result.read_data   = rd_reg;
        result.flushed     = flushed_reg;
        result.page_mapped = cfg.auto_allocate || (op_reg.in_map && mapped_reg);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wb_ret_reg    <= BK_DONE;
            alloc_ret_reg <= BK_DONE;
            buf_page_reg  <= 8'd0;
            dirty_reg     <= 1'b0;
            last_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
            map_valid_reg <= '0;
            buf_valid_reg <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wb_ret_reg    <= wb_ret_next;
            alloc_ret_reg <= alloc_ret_next;
            buf_page_reg  <= buf_page_next;
            dirty_reg     <= dirty_next;
            last_reg      <= last_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (map_wr_en)
                map_valid_reg[map_wr_addr] <= 1'b1;
            if (buf_clear)
                buf_valid_reg <= '0;
            else if (buf_wr_en)
                buf_valid_reg[buf_wr_addr] <= 1'b1;
            if (row_set)
                row_valid_reg[bp_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        fp_reg       <= fp_next;
        status_reg   <= status_next;
        rd_reg       <= rd_next;
        flushed_reg  <= flushed_next;
        mapped_reg   <= mapped_next;
        cnt_reg      <= cnt_next;
        range_p_reg  <= range_p_next;
        alloc_vp_reg <= alloc_vp_next;
        sel_buf_reg  <= sel_buf_next;
        if (out_load)
            out_reg <= result;
    end

    always_ff @(posedge clk)
    begin
        if (map_wr_en)
            map_mem[map_wr_addr] <= last_reg;
        map_rd_data_reg <= map_mem[map_rd_addr];
        map_rd_vld_reg  <= map_valid_reg[map_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr_en)
            buf_mem[buf_wr_addr] <= buf_wr_data;
        buf_rd_data_reg <= buf_mem[buf_rd_addr];
        buf_rd_vld_reg  <= buf_valid_reg[buf_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flash_wr_en)
            flash_mem[flash_wr_addr] <= buf_val;
        flash_rd_data_reg <= flash_mem[flash_rd_addr];
        flash_rd_ok_reg   <= flash_rd_ok;
    end

endmodule

>>> src/flash_page_mapper_top.sv
// ----------------------------------------------------------------------------
// flash_page_mapper_top
// Byte-addressed virtual memory kept in flash pages behind a page map.
// ----------------------------------------------------------------------------
// A byte read that hits the write buffer or a written flash page passes the
// lookup, read and read-wait states before its word is returned, a byte write
// to the page already held the lookup, write-alloc and write states; a small
// decoded-op queue lets the input side keep accepting while it has room.
// Anything that moves a whole page goes one byte a cycle through the buffer
// and flash memories: a write-back of a dirty buffer and a page load each
// sweep the whole page. The first allocation after reset (and any while no
// page is yet allocated) scans the page map. An add-range command reads and
// checks the map entry of each page in the range, and allocates as above.
module flash_page_mapper_top #(
    parameter int MAP_ENTRIES = 256,
    parameter int DATA_PAGES  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address, write_data, length_bytes, force_flash, zero pad
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status, read_data, flushed, page_mapped, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import fpm_pkg::*;

    cfg_t cfg_reg, cfg_next;
    op_t  front_op, queue_op;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TABLE_PAGE:    cfg_next.table_page    = cfg_data;
                CFG_REGION_PAGES:  cfg_next.region_pages  = cfg_data[6:0];
                CFG_AUTO_ALLOCATE: cfg_next.auto_allocate = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_page    <= 8'd0;
            cfg_reg.region_pages  <= 7'd65;
            cfg_reg.auto_allocate <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    fpm_front #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op       (front_op)
    );

    fpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_op     (front_op),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_op    (queue_op)
    );

    fpm_back #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .DATA_PAGES  (DATA_PAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op_valid (queue_valid),
        .op_ready (queue_ready),
        .op_in    (queue_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/flash_page_mapper_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_mapper_top_test
// Drives commands into the page mapper and checks every result word against
// a predictor that keeps its own page map, flash image and write buffer.
// ----------------------------------------------------------------------------
module flash_page_mapper_top_test;
    import fpm_pkg::*;

    localparam int MAP_N   = 256;
    localparam int SLOTS   = 64;
    localparam int PAGE_SZ = 256;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] address;
        logic [7:0]  wdata;
        logic [16:0] length;
        logic        force_rd;
    } mem_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    flash_page_mapper_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0] map_tbl [MAP_N];
    logic [7:0] flash_img [SLOTS*PAGE_SZ];
    logic [7:0] wbuf [PAGE_SZ];
    int         held_page;
    bit         held_dirty;
    int         last_alloc;
    bit         flushed_now;
    int         tbl_page;
    int         region_n;
    bit         auto_alloc;

    mem_cmd_t   pending_cmds[$];
    result_t    expected_results[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_off;
    int         fail_count;

    function automatic bit slot_of(int page, output int slot);
        if (page <= tbl_page)
            return 0;
        slot = page - tbl_page - 1;
        return slot < SLOTS;
    endfunction

    function automatic void write_back();
        int s;
        if (!held_dirty)
            return;
        if (slot_of(held_page, s))
            for (int i = 0; i < PAGE_SZ; i++)
                flash_img[s*PAGE_SZ+i] = wbuf[i];
        held_dirty = 0;
        flushed_now = 1;
    endfunction

    function automatic logic [7:0] flash_byte(int page, int idx);
        int s;
        if (!slot_of(page, s))
            return ERASED;
        return flash_img[s*PAGE_SZ+idx];
    endfunction

    function automatic status_t allocate_page(int vp);
        int cap;
        int top;
        int start;
        if (last_alloc == 0)
            for (int i = 0; i < MAP_N; i++)
                if (map_tbl[i] > last_alloc)
                    last_alloc = map_tbl[i];
        cap = region_n >= 1 ? region_n - 1 : 0;
        if (cap > SLOTS)
            cap = SLOTS;
        top = tbl_page + cap;
        if (top > 255)
            top = 255;
        start = (last_alloc <= tbl_page) ? tbl_page + 1 : last_alloc + 1;
        if (start > top)
            return ST_NO_MEM;
        last_alloc = start;
        write_back();
        map_tbl[vp] = 8'(start);
        held_page = start;
        for (int i = 0; i < PAGE_SZ; i++)
            wbuf[i] = 8'h00;
        held_dirty = 0;
        return ST_OK;
    endfunction

    function automatic result_t predict_access(mem_cmd_t c);
        result_t r;
        int vp;
        int idx;
        int fp;
        int pages;
        status_t st;
        vp = c.address[15:8];
        idx = c.address[7:0];
        st = ST_OK;
        r = '0;
        flushed_now = 0;
        case (c.cmd)
            CMD_READ:
            begin
                fp = map_tbl[vp];
                if (c.force_rd)
                    write_back();
                if (fp == 0)
                    st = ST_UNMAPPED;
                else if (fp == held_page && !c.force_rd)
                    r.read_data = wbuf[idx];
                else
                    r.read_data = flash_byte(fp, idx);
            end
            CMD_WRITE:
            begin
                fp = map_tbl[vp];
                if (fp == 0 && !auto_alloc)
                    st = ST_UNMAPPED;
                else
                begin
                    if (held_page != fp)
                    begin
                        write_back();
                        held_page = fp;
                        for (int i = 0; i < PAGE_SZ; i++)
                            wbuf[i] = flash_byte(fp, i);
                    end
                    if (fp == 0)
                        st = allocate_page(vp);
                    if (st == ST_OK)
                    begin
                        wbuf[idx] = c.wdata;
                        held_dirty = 1;
                    end
                end
            end
            CMD_RANGE:
            begin
                pages = c.length >> 8;
                if (c.length == 0 || c.length[7:0] != 0)
                    st = ST_BAD_LEN;
                else if (idx != 0)
                    st = ST_BAD_ADDR;
                else if (vp + pages > MAP_N)
                    st = ST_BAD_LEN;
                else
                begin
                    for (int p = vp; p < vp + pages && st == ST_OK; p++)
                        if (map_tbl[p] == 0)
                            st = allocate_page(p);
                    if (st == ST_OK)
                        write_back();
                end
            end
            default:
                write_back();
        endcase
        r.status = st;
        r.flushed = flushed_now;
        r.page_mapped = auto_alloc || map_tbl[vp] != 0;
        return r;
    endfunction

    function automatic mem_cmd_t random_cmd();
        mem_cmd_t c;
        int k;
        c.address = 16'($urandom);
        c.wdata = 8'($urandom);
        c.length = 17'($urandom);
        c.force_rd = 1'($urandom);
        k = $urandom_range(0, 99);
        if (k < 40)
        begin
            c.cmd = CMD_WRITE;
            c.address[15:8] = 8'($urandom_range(0, 15));
        end
        else if (k < 80)
        begin
            c.cmd = CMD_READ;
            c.address[15:8] = 8'($urandom_range(0, 15));
            c.force_rd = ($urandom_range(0, 9) == 0);
        end
        else if (k < 92)
        begin
            c.cmd = CMD_RANGE;
            if ($urandom_range(0, 3) != 0)
            begin
                c.address[7:0] = 0;
                c.address[15:8] = 8'($urandom_range(0, 20));
                c.length = 17'($urandom_range(1, 3) << 8);
            end
        end
        else
            c.cmd = CMD_FLUSH;
        return c;
    endfunction

    function automatic mem_cmd_t make_cmd(cmd_t op, int addr, int wd, int len, bit frc);
        mem_cmd_t c;
        c.cmd = op;
        c.address = 16'(addr);
        c.wdata = 8'(wd);
        c.length = 17'(len);
        c.force_rd = frc;
        return c;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_results.push_back(predict_access({cmd_t'(s_tuser),
                    s_tdata[15:0], s_tdata[23:16], s_tdata[40:24], s_tdata[41]}));
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                mem_cmd_t c;
                c = pending_cmds.pop_front();
                s_tvalid <= 1;
                s_tuser <= c.cmd;
                s_tdata <= {6'b0, c.force_rd, c.length, c.wdata, c.address};
            end
            else
                s_tvalid <= 0;
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_t got;
                result_t want;
                got = m_tdata[12:0];
                if (expected_results.size() == 0)
                begin
                    $error("result word with none expected: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h actual %h", want.read_data,
                            got.read_data);
                        fail_count++;
                    end
                    if (got.flushed !== want.flushed)
                    begin
                        $error("flushed: expected %0b actual %0b", want.flushed, got.flushed);
                        fail_count++;
                    end
                    if (got.page_mapped !== want.page_mapped)
                    begin
                        $error("page_mapped: expected %0b actual %0b", want.page_mapped,
                            got.page_mapped);
                        fail_count++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= 8'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        case (idx)
            CFG_TABLE_PAGE: tbl_page = val & 8'hff;
            CFG_REGION_PAGES: region_n = val & 8'h7f;
            default: auto_alloc = val[0];
        endcase
        @(posedge clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            pending_cmds.push_back(random_cmd());
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < MAP_N; i++) map_tbl[i] = 0;
        for (int i = 0; i < SLOTS*PAGE_SZ; i++) flash_img[i] = ERASED;
        for (int i = 0; i < PAGE_SZ; i++) wbuf[i] = 0;
        held_page = 0; held_dirty = 0; last_alloc = 0;
        tbl_page = 0; region_n = 65; auto_alloc = 0;
        fail_count = 0; hold_off = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg_valid = 0; cfg_index = CFG_TABLE_PAGE; cfg_data = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: unmapped accesses, ranges, errors, auto allocation
        pending_cmds.push_back(make_cmd(CMD_READ, 16'h0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 16'hffff, 8'hff, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_RANGE, 16'h0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_RANGE, 16'h0000, 0, 17'h00180, 0));
        pending_cmds.push_back(make_cmd(CMD_RANGE, 16'h0001, 0, 17'h00100, 0));
        pending_cmds.push_back(make_cmd(CMD_RANGE, 16'hff00, 0, 17'h00200, 1));
        pending_cmds.push_back(make_cmd(CMD_RANGE, 16'h0000, 0, 17'h10000, 0));
        pending_cmds.push_back(make_cmd(CMD_RANGE, 16'h0200, 0, 17'h00200, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h0205, 8'h5a, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h03ff, 8'h00, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 16'h0205, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 16'h0205, 0, 0, 1));
        pending_cmds.push_back(make_cmd(CMD_FLUSH, 16'hffff, 8'hff, 17'h1ffff, 1));
        pending_cmds.push_back(make_cmd(CMD_READ, 16'h03ff, 0, 0, 1));
        wait_drained();
        write_reg(CFG_AUTO_ALLOCATE, 1);
        write_reg(CFG_REGION_PAGES, 4);
        pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h4010, 8'h11, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h5010, 8'h22, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h6010, 8'h33, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 16'h4010, 0, 0, 1));
        pending_cmds.push_back(make_cmd(CMD_FLUSH, 0, 0, 0, 0));
        wait_drained();

        // random phases over several register settings
        write_reg(CFG_TABLE_PAGE, 8'hf0);
        write_reg(CFG_REGION_PAGES, 127);
        run_phase(250, 0, 0);
        write_reg(CFG_TABLE_PAGE, 10);
        write_reg(CFG_REGION_PAGES, 2);
        write_reg(CFG_AUTO_ALLOCATE, 0);
        run_phase(250, 52, 0);
        write_reg(CFG_AUTO_ALLOCATE, 1);
        write_reg(CFG_REGION_PAGES, 40);
        write_reg(CFG_TABLE_PAGE, 0);
        run_phase(250, 0, 52);
        write_reg(CFG_TABLE_PAGE, 255);
        write_reg(CFG_REGION_PAGES, 65);
        run_phase(250, 11, 11);
        write_reg(CFG_TABLE_PAGE, 3);
        write_reg(CFG_REGION_PAGES, 127);
        run_phase(250, 0, 0);

        // long receiver hold-off while the sender keeps offering
        hold_off = 400;
        run_phase(200, 0, 0);
        write_reg(CFG_AUTO_ALLOCATE, 0);
        run_phase(250, 52, 52);
        write_reg(CFG_AUTO_ALLOCATE, 1);
        write_reg(CFG_REGION_PAGES, 20);
        run_phase(250, 11, 11);

        if (fail_count == 0)
            $display("flash_page_mapper_top test passed");
        else
            $display("flash_page_mapper_top test failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("flash_page_mapper_top test failed");
        $finish;
    end
endmodule
